### rtl/dcmt_pkg.sv
// Shared types and constants for the dual compare-match timer.
`default_nettype none
package dcmt_pkg;
	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_TICK  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam logic [7:0]  STATUS_RESET = 8'hC0;
	localparam logic [15:0] UNMAPPED     = 16'hFFFF;
	localparam logic [15:0] CMP_RESET    = 16'hFFFF;
	localparam logic [2:0]  CLR_ON_A     = 3'd1;
	localparam logic [2:0]  CLR_ON_B     = 3'd2;

	localparam logic [7:0] A_CTRL0  = 8'h00;
	localparam logic [7:0] A_CTRL1  = 8'h01;
	localparam logic [7:0] A_MODE0  = 8'h02;
	localparam logic [7:0] A_MODE1  = 8'h03;
	localparam logic [7:0] A_IOH0   = 8'h04;
	localparam logic [7:0] A_IOL0   = 8'h05;
	localparam logic [7:0] A_IOH1   = 8'h06;
	localparam logic [7:0] A_IOL1   = 8'h07;
	localparam logic [7:0] A_IEN0   = 8'h08;
	localparam logic [7:0] A_IEN1   = 8'h09;
	localparam logic [7:0] A_CNT0   = 8'h10;
	localparam logic [7:0] A_CNT1   = 8'h12;
	localparam logic [7:0] A_CMPA0  = 8'h18;
	localparam logic [7:0] A_CMPB0  = 8'h1A;
	localparam logic [7:0] A_CMPA1  = 8'h1C;
	localparam logic [7:0] A_CMPB1  = 8'h1E;
	localparam logic [7:0] A_CMPC0  = 8'h24;
	localparam logic [7:0] A_CMPD0  = 8'h26;
	localparam logic [7:0] A_CMPC1  = 8'h28;
	localparam logic [7:0] A_CMPD1  = 8'h2A;
	localparam logic [7:0] A_STAT0  = 8'h2C;
	localparam logic [7:0] A_STAT1  = 8'h2D;
	localparam logic [7:0] A_START  = 8'h80;

	// Prescaler terminal value (divider minus one) for a prescale code.
	function automatic logic [9:0] prescale_last(input logic [2:0] code);
		logic [9:0] r;
		case (code)
			3'd1: r = 10'd3;
			3'd2: r = 10'd15;
			3'd3: r = 10'd63;
			3'd4: r = 10'd255;
			3'd5: r = 10'd1023;
			default: r = 10'd0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

### rtl/dual_compare_match_timer.sv
// Top level of the two-channel compare-match timer with its register window.
// Every accepted beat yields one registered result beat.
// Throughput: one beat per cycle while out_stall is low; the result register frees as it is taken.
// All register work happens in one combinational pass from the input beat to the result register.
// Reset: arst_n clears start, control and counter state; status reads 0xC0,
// compare registers read 0xFFFF.
`default_nettype none
module dual_compare_match_timer #(
	parameter int NUM_CHANNELS = 2
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [1:0]  operation,
	input  wire  [7:0]  address,
	input  wire  [15:0] write_data,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [15:0] read_data,
	output logic [5:0]  irq_pulses
);
	import dcmt_pkg::*;

	logic [1:0]  start_q;
	logic [7:0]  ctrl_q [2];
	logic [7:0]  mode_q [2];
	logic [7:0]  ioh_q [2];
	logic [7:0]  iol_q [2];
	logic [7:0]  ien_q [2];
	logic [7:0]  stat_q [2];
	logic [15:0] cnt_q [2];
	logic [15:0] cmp_q [8];
	logic [9:0]  pre_q [2];

	logic [1:0]  start_d;
	logic [7:0]  ctrl_d [2];
	logic [7:0]  mode_d [2];
	logic [7:0]  ioh_d [2];
	logic [7:0]  iol_d [2];
	logic [7:0]  ien_d [2];
	logic [7:0]  stat_d [2];
	logic [15:0] cnt_d [2];
	logic [15:0] cmp_d [8];
	logic [9:0]  pre_d [2];
	logic [15:0] rd_d;
	logic [5:0]  irq_d;

	logic        acc;
	logic [1:0]  chan_mask;
	op_t         op;

	assign chan_mask = (NUM_CHANNELS >= 2) ? 2'b11 : 2'b01;
	assign in_stall  = out_valid && out_stall;
	assign acc       = in_valid && !in_stall;
	assign op        = op_t'(operation);

	always_comb begin
		logic [16:0] nxt;
		logic [15:0] c;
		logic [2:0]  clr;
		logic [7:0]  lo;
		logic [1:0]  ch;
		start_d = start_q;
		ctrl_d  = ctrl_q;
		mode_d  = mode_q;
		ioh_d   = ioh_q;
		iol_d   = iol_q;
		ien_d   = ien_q;
		stat_d  = stat_q;
		cnt_d   = cnt_q;
		cmp_d   = cmp_q;
		pre_d   = pre_q;
		rd_d    = '0;
		irq_d   = '0;
		lo      = write_data[7:0];
		nxt     = '0;
		c       = '0;
		clr     = '0;
		// Channel bit of the address; absent channels are masked off where it is used.
		ch = 2'b01 << address[0];
		case (address)
			A_CNT1, A_CMPA1, A_CMPB1, A_CMPC1, A_CMPD1, A_IOH1, A_IOL1: ch = 2'b10;
			A_CNT0, A_CMPA0, A_CMPB0, A_CMPC0, A_CMPD0, A_IOH0, A_IOL0: ch = 2'b01;
			default: ;
		endcase
		unique case (op)
			OP_READ: begin
				rd_d = UNMAPPED;
				if ((ch & chan_mask) != 2'b00 || address == A_START) begin
					unique case (address)
						A_CTRL0, A_CTRL1: rd_d = {8'h00, ctrl_q[address[0]]};
						A_MODE0, A_MODE1: rd_d = {8'h00, mode_q[address[0]]};
						A_IOH0:  rd_d = {8'h00, ioh_q[0]};
						A_IOL0:  rd_d = {8'h00, iol_q[0]};
						A_IOH1:  rd_d = {8'h00, ioh_q[1]};
						A_IOL1:  rd_d = {8'h00, iol_q[1]};
						A_IEN0, A_IEN1: rd_d = {8'h00, ien_q[address[0]]};
						A_CNT0:  rd_d = cnt_q[0];
						A_CNT1:  rd_d = cnt_q[1];
						A_CMPA0: rd_d = cmp_q[0];
						A_CMPB0: rd_d = cmp_q[1];
						A_CMPC0: rd_d = cmp_q[2];
						A_CMPD0: rd_d = cmp_q[3];
						A_CMPA1: rd_d = cmp_q[4];
						A_CMPB1: rd_d = cmp_q[5];
						A_CMPC1: rd_d = cmp_q[6];
						A_CMPD1: rd_d = cmp_q[7];
						A_STAT0, A_STAT1: rd_d = {8'h00, stat_q[address[0]]};
						A_START: rd_d = {8'h00, start_q, 6'b0};
						default: rd_d = UNMAPPED;
					endcase
				end
			end
			OP_WRITE: begin
				if ((ch & chan_mask) != 2'b00 || address == A_START) begin
					unique case (address)
						A_CTRL0, A_CTRL1: ctrl_d[address[0]] = lo;
						A_MODE0, A_MODE1: mode_d[address[0]] = lo;
						A_IOH0:  ioh_d[0] = lo;
						A_IOL0:  iol_d[0] = lo;
						A_IOH1:  ioh_d[1] = lo;
						A_IOL1:  iol_d[1] = lo;
						A_IEN0, A_IEN1: ien_d[address[0]] = lo;
						A_CNT0: begin
							cnt_d[0] = write_data;
							pre_d[0] = '0;
						end
						A_CNT1: begin
							cnt_d[1] = write_data;
							pre_d[1] = '0;
						end
						A_CMPA0: cmp_d[0] = write_data;
						A_CMPB0: cmp_d[1] = write_data;
						A_CMPC0: cmp_d[2] = write_data;
						A_CMPD0: cmp_d[3] = write_data;
						A_CMPA1: cmp_d[4] = write_data;
						A_CMPB1: cmp_d[5] = write_data;
						A_CMPC1: cmp_d[6] = write_data;
						A_CMPD1: cmp_d[7] = write_data;
						A_STAT0, A_STAT1: stat_d[address[0]] = stat_q[address[0]] & lo;
						A_START: begin
							start_d = lo[7:6] & chan_mask;
							for (int i = 0; i < 2; i++) begin
								if (start_d[i] && !start_q[i]) pre_d[i] = '0;
							end
						end
						default: ;
					endcase
				end
			end
			OP_TICK: begin
				for (int i = 0; i < 2; i++) begin
					if (start_q[i] && chan_mask[i]) begin
						if (pre_q[i] >= prescale_last(ctrl_q[i][2:0])) begin
							pre_d[i] = '0;
							clr = ctrl_q[i][5:3];
							nxt = {1'b0, cnt_q[i]} + 17'd1;
							if (nxt[16]) begin
								stat_d[i][4] = 1'b1;
								irq_d[3*i+2] = ien_q[i][4];
							end
							c = nxt[15:0];
							cnt_d[i] = c;
							if (c == cmp_q[4*i]) begin
								stat_d[i][0] = 1'b1;
								irq_d[3*i] = ien_q[i][0];
							end
							// Clearing on A suppresses the B check.
							if (c == cmp_q[4*i] && clr == CLR_ON_A) begin
								cnt_d[i] = '0;
							end else if (cmp_q[4*i+1] != CMP_RESET && c == cmp_q[4*i+1]) begin
								stat_d[i][1] = 1'b1;
								irq_d[3*i+1] = ien_q[i][1];
								if (clr == CLR_ON_B) cnt_d[i] = '0;
							end
						end else begin
							pre_d[i] = pre_q[i] + 10'd1;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= '0;
			out_valid <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				ctrl_q[i] <= '0;
				mode_q[i] <= '0;
				ioh_q[i]  <= '0;
				iol_q[i]  <= '0;
				ien_q[i]  <= '0;
				stat_q[i] <= STATUS_RESET;
				cnt_q[i]  <= '0;
				pre_q[i]  <= '0;
			end
			for (int j = 0; j < 8; j++) cmp_q[j] <= CMP_RESET;
		end else begin
			if (acc) begin
				start_q <= start_d;
				ctrl_q  <= ctrl_d;
				mode_q  <= mode_d;
				ioh_q   <= ioh_d;
				iol_q   <= iol_d;
				ien_q   <= ien_d;
				stat_q  <= stat_d;
				cnt_q   <= cnt_d;
				cmp_q   <= cmp_d;
				pre_q   <= pre_d;
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			read_data  <= rd_d;
			irq_pulses <= irq_d;
		end
	end

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_data))
		else $error("result beat changed while stalled");
	a_irq_tick: assert property (@(posedge clk) disable iff (!arst_n)
		acc && op != OP_TICK |=> irq_pulses == 6'd0)
		else $error("interrupt pulse outside a tick");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start_q & ~chan_mask) == 2'b00)
		else $error("absent channel started");
`endif
endmodule
`default_nettype wire

### tb/sv/tb_dual_compare_match_timer.sv
// Self-checking testbench for the dual compare-match timer: queued bus and tick beats, predicted results.
`timescale 1ns / 100ps
`default_nettype none
module tb_dual_compare_match_timer;
	import dcmt_pkg::*;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  addr;
		logic [15:0] data;
	} bus_beat_t;

	typedef struct packed {
		logic [15:0] rd;
		logic [5:0]  irq;
	} timer_result_t;

	typedef enum int {
		K_NONE, K_CTRL, K_MODE, K_IOH, K_IOL, K_IEN, K_CNT, K_CMP, K_STAT, K_START
	} reg_kind_t;

	localparam int CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  operation = '0;
	logic [7:0]  address = '0;
	logic [15:0] write_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] read_data;
	logic [5:0]  irq_pulses;

	dual_compare_match_timer u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .address(address), .write_data(write_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.read_data(read_data), .irq_pulses(irq_pulses)
	);

	always #10 clk = ~clk;

	// Predictor state.
	logic [1:0]  p_start;
	logic [7:0]  p_ctrl [2];
	logic [7:0]  p_mode [2];
	logic [7:0]  p_ioh [2];
	logic [7:0]  p_iol [2];
	logic [7:0]  p_ien [2];
	logic [7:0]  p_stat [2];
	logic [15:0] p_cnt [2];
	logic [15:0] p_cmp [8];
	logic [9:0]  p_pre [2];

	bus_beat_t     pending_beats[$];
	timer_result_t expected_results[$];
	int            mismatches = 0;
	int            cycles = 0;
	int            send_idle_pct = 0;
	int            recv_stall_pct = 0;
	int            hold_cnt = 0;
	bit            hold_req = 0;
	bit            hold_used = 0;
	bit            in_taken = 0;

	task automatic timer_reset_model();
		p_start = '0;
		for (int i = 0; i < 2; i++) begin
			p_ctrl[i] = '0; p_mode[i] = '0; p_ioh[i] = '0; p_iol[i] = '0;
			p_ien[i] = '0; p_stat[i] = STATUS_RESET; p_cnt[i] = '0; p_pre[i] = '0;
		end
		for (int i = 0; i < 8; i++) p_cmp[i] = CMP_RESET;
	endtask

	function automatic int divider_of(input logic [2:0] code);
		case (code)
			3'd1: return 4;
			3'd2: return 16;
			3'd3: return 64;
			3'd4: return 256;
			3'd5: return 1024;
			default: return 1;
		endcase
	endfunction

	function automatic logic [2:0] advance_counter(input int c);
		logic [2:0]  pulses;
		logic [2:0]  clr;
		logic [16:0] nxt;
		logic [15:0] a, b;
		pulses = '0;
		clr = p_ctrl[c][5:3];
		nxt = {1'b0, p_cnt[c]} + 17'd1;
		a = p_cmp[c*4];
		b = p_cmp[c*4+1];
		if (nxt[16]) begin
			p_stat[c][4] = 1'b1;
			if (p_ien[c][4]) pulses[2] = 1'b1;
		end
		p_cnt[c] = nxt[15:0];
		if (p_cnt[c] == a) begin
			p_stat[c][0] = 1'b1;
			if (p_ien[c][0]) pulses[0] = 1'b1;
			if (clr == CLR_ON_A) begin
				p_cnt[c] = '0;
				return pulses;
			end
		end
		if (b != 16'hFFFF && p_cnt[c] == b) begin
			p_stat[c][1] = 1'b1;
			if (p_ien[c][1]) pulses[1] = 1'b1;
			if (clr == CLR_ON_B) p_cnt[c] = '0;
		end
		return pulses;
	endfunction

	// Decodes an address into a register kind; K_NONE when unmapped.
	function automatic reg_kind_t decode_addr(input logic [7:0] a, output int c,
			output int sub);
		c = 0; sub = 0;
		case (a)
			A_CTRL0, A_CTRL1: begin c = int'(a[0]); return K_CTRL; end
			A_MODE0, A_MODE1: begin c = int'(a[0]); return K_MODE; end
			A_IOH0: begin c = 0; return K_IOH; end
			A_IOL0: begin c = 0; return K_IOL; end
			A_IOH1: begin c = 1; return K_IOH; end
			A_IOL1: begin c = 1; return K_IOL; end
			A_IEN0, A_IEN1: begin c = int'(a[0]); return K_IEN; end
			A_CNT0: begin c = 0; return K_CNT; end
			A_CNT1: begin c = 1; return K_CNT; end
			A_CMPA0: begin c = 0; sub = 0; return K_CMP; end
			A_CMPB0: begin c = 0; sub = 1; return K_CMP; end
			A_CMPA1: begin c = 1; sub = 0; return K_CMP; end
			A_CMPB1: begin c = 1; sub = 1; return K_CMP; end
			A_CMPC0: begin c = 0; sub = 2; return K_CMP; end
			A_CMPD0: begin c = 0; sub = 3; return K_CMP; end
			A_CMPC1: begin c = 1; sub = 2; return K_CMP; end
			A_CMPD1: begin c = 1; sub = 3; return K_CMP; end
			A_STAT0, A_STAT1: begin c = int'(a[0]); return K_STAT; end
			A_START: return K_START;
			default: return K_NONE;
		endcase
	endfunction

	function automatic timer_result_t predict_timer(input bus_beat_t b);
		timer_result_t r;
		reg_kind_t kind;
		int c, sub;
		logic [1:0] prev;
		r = '0;
		kind = decode_addr(b.addr, c, sub);
		case (b.op)
			OP_READ: begin
				case (kind)
					K_CTRL:  r.rd = {8'd0, p_ctrl[c]};
					K_MODE:  r.rd = {8'd0, p_mode[c]};
					K_IOH:   r.rd = {8'd0, p_ioh[c]};
					K_IOL:   r.rd = {8'd0, p_iol[c]};
					K_IEN:   r.rd = {8'd0, p_ien[c]};
					K_CNT:   r.rd = p_cnt[c];
					K_CMP:   r.rd = p_cmp[c*4+sub];
					K_STAT:  r.rd = {8'd0, p_stat[c]};
					K_START: r.rd = {8'd0, p_start, 6'd0};
					default: r.rd = UNMAPPED;
				endcase
			end
			OP_WRITE: begin
				case (kind)
					K_CTRL: p_ctrl[c] = b.data[7:0];
					K_MODE: p_mode[c] = b.data[7:0];
					K_IOH:  p_ioh[c] = b.data[7:0];
					K_IOL:  p_iol[c] = b.data[7:0];
					K_IEN:  p_ien[c] = b.data[7:0];
					K_CNT: begin p_cnt[c] = b.data; p_pre[c] = '0; end
					K_CMP:  p_cmp[c*4+sub] = b.data;
					K_STAT: p_stat[c] = p_stat[c] & b.data[7:0];
					K_START: begin
						prev = p_start;
						p_start = b.data[7:6];
						for (int i = 0; i < 2; i++)
							if (p_start[i] && !prev[i]) p_pre[i] = '0;
					end
					default: ;
				endcase
			end
			OP_TICK: begin
				for (int i = 0; i < 2; i++) begin
					if (!p_start[i]) continue;
					if (int'(p_pre[i]) + 1 >= divider_of(p_ctrl[i][2:0])) begin
						p_pre[i] = '0;
						r.irq[i*3 +: 3] = advance_counter(i);
					end else begin
						p_pre[i] = p_pre[i] + 10'd1;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic push_beat(input logic [1:0] op, input logic [7:0] a, input logic [15:0] d);
		bus_beat_t b;
		b.op = op; b.addr = a; b.data = d;
		pending_beats.push_back(b);
	endtask

	function automatic logic [7:0] random_address();
		logic [7:0] list [23];
		list = '{A_CTRL0, A_CTRL1, A_MODE0, A_MODE1, A_IOH0, A_IOL0, A_IOH1, A_IOL1,
			A_IEN0, A_IEN1, A_CNT0, A_CNT1, A_CMPA0, A_CMPB0, A_CMPA1, A_CMPB1,
			A_CMPC0, A_CMPD0, A_CMPC1, A_CMPD1, A_STAT0, A_STAT1, A_START};
		if ($urandom_range(9) == 0) return 8'($urandom);
		return list[$urandom_range(22)];
	endfunction

	// A random phase: mostly ticks with counters near compare values, plus bus traffic.
	task automatic random_phase(input int n);
		int k;
		logic [15:0] d;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			if (k < 55) push_beat(OP_TICK, 8'($urandom), 16'($urandom));
			else if (k < 60) push_beat(OP_NONE, 8'($urandom), 16'($urandom));
			else if (k < 78) push_beat(OP_READ, random_address(), 16'($urandom));
			else begin
				d = 16'($urandom);
				case ($urandom_range(5))
					0: d = {8'($urandom), 2'($urandom), 3'($urandom_range(2)),
						3'($urandom_range(7))};
					1: d = 16'($urandom_range(12));
					2: d = 16'hFFF0 + 16'($urandom_range(15));
					default: ;
				endcase
				push_beat(OP_WRITE, random_address(), d);
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_beats.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Long receiver hold-off, counted in cycles.
	always @(posedge clk) begin
		if (hold_req && !hold_used) begin
			hold_cnt <= 60;
			hold_used <= 1'b1;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	// Driver. A beat that was offered and not taken stays on the bus unchanged.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!(in_valid && !in_taken)) begin
				if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					operation <= pending_beats[0].op;
					address <= pending_beats[0].addr;
					write_data <= pending_beats[0].data;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= (hold_cnt > 0) || ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Predicts accepted beats and checks results.
	always @(posedge clk) begin
		timer_result_t got, want;
		cycles <= cycles + 1;
		in_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			expected_results.push_back(predict_timer(pending_beats.pop_front()));
		end
		if (arst_n && out_valid && !out_stall) begin
			got.rd = read_data;
			got.irq = irq_pulses;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected result beat rd=%h irq=%h", got.rd, got.irq);
			end else begin
				want = expected_results.pop_front();
				if (got.rd !== want.rd || got.irq !== want.irq) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: read_data exp %h got %h, irq_pulses exp %h got %h",
							want.rd, got.rd, want.irq, got.irq);
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		timer_reset_model();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: reset values, extremes, compare matches, wrap, clear modes.
		push_beat(OP_READ, A_STAT0, 16'h0);
		push_beat(OP_READ, A_CMPA1, 16'h0);
		push_beat(OP_READ, 8'hFF, 16'hFFFF);
		push_beat(OP_READ, 8'h11, 16'h0);
		push_beat(OP_NONE, 8'hFF, 16'hFFFF);
		push_beat(OP_WRITE, A_IEN0, 16'hFFFF);
		push_beat(OP_WRITE, A_IEN1, 16'h0013);
		push_beat(OP_WRITE, A_CTRL0, 16'h0008);
		push_beat(OP_WRITE, A_CMPA0, 16'h0002);
		push_beat(OP_WRITE, A_CNT0, 16'hFFFE);
		push_beat(OP_WRITE, A_CTRL1, 16'h0011);
		push_beat(OP_WRITE, A_CMPB1, 16'h0000);
		push_beat(OP_WRITE, A_CNT1, 16'hFFFF);
		push_beat(OP_WRITE, A_START, 16'hFFFF);
		repeat (8) push_beat(OP_TICK, 8'h00, 16'h0000);
		push_beat(OP_READ, A_STAT0, 16'h0);
		push_beat(OP_WRITE, A_STAT0, 16'h00EE);
		push_beat(OP_READ, A_START, 16'h0);
		wait_drained();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
				3: begin send_idle_pct = 10; recv_stall_pct = 10; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; hold_req = 1; end
			endcase
			random_phase(90);
			wait_drained();
		end

		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
`default_nettype wire
